// ===== src/pac_pkg.sv =====
// Shared constants, types and control structs of the proximity array centroid core.
// No dependencies; imported by every module of the block.
package pac_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int N_PROX      = 6;
    localparam int IDX_W       = 3;
    localparam int LEVEL_W     = 7;
    localparam int POS_W       = 8;
    localparam int QUOT_W      = 8;
    localparam int STEP_W      = 3;
    localparam int DIVIDEND_W  = SAMPLE_BITS + QUOT_W - 1;
    localparam int ACC_W       = 15;
    localparam int CNT_W       = 3;
    localparam int POS_DIV_W   = 8;
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;

    localparam int FULL_SCALE  = 100;
    localparam int IDX_STEP    = 1000;
    localparam int SPAN_LOW    = -3500;
    localparam int SPAN_HIGH   = 3500;
    localparam int POS_LOW     = -100;
    localparam int POS_HIGH    = 100;
    // avg * 200 / 7000 reduces to avg / 35
    localparam int POS_STEP    = (SPAN_HIGH - SPAN_LOW) / (POS_HIGH - POS_LOW);
    localparam int POS_OFFSET  = -POS_LOW;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_PROX - 1);

    localparam logic [SAMPLE_BITS-1:0] DETECT_LOW_RST  = SAMPLE_BITS'(100);
    localparam logic [SAMPLE_BITS-1:0] DETECT_HIGH_RST = SAMPLE_BITS'(600);
    localparam logic [SAMPLE_BITS-1:0] LINE_LEVEL_RST  = SAMPLE_BITS'(300);

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_DETECT_LOW  = 2'd0;
    localparam logic [1:0] REG_DETECT_HIGH = 2'd1;
    localparam logic [1:0] REG_LINE_LEVEL  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_PSTART,
        ST_PWAIT,
        ST_FINISH
    } pac_state_t;

    typedef struct packed {
        logic             capture;
        logic             div_start;
        logic             div_pos;
        logic             level_store;
        logic             pos_store;
        logic             publish;
        logic [IDX_W-1:0] idx;
    } pac_cmd_t;

    typedef struct packed {
        logic div_done;
        logic any_seen;
        logic out_free;
    } pac_status_t;

endpackage

// ===== src/proximity_array_centroid_core.sv =====
// Top level of the proximity array centroid core: APB registers, sequencer, datapath.
// Depends on pac_pkg, pac_ctrl and pac_dp.
//
// Usage:
// - Input channel (in_valid / in_stall): one word is one scan of six proximity
//   samples and two floor samples, taken when in_valid is high and in_stall low.
// - Output channel (out_valid / out_stall): one word per scan with six levels
//   (0..100), two line flags, the centroid position and any_seen.
// - Each scan runs its six levels and then, if a sensor sees, the centroid through
//   one shared restoring divider, 8 quotient bits at one bit per cycle. A new
//   scan is taken only once the last one has gone to the output register.
// - The output register frees the datapath: a word may wait on out_stall while
//   the next scan is taken and worked on; a finished scan then waits until the
//   output register is free. A stalled word holds its value.
// - When no sensor sees, the position of the last scan that saw is repeated.
// - Reset: thresholds return to 100 / 600 / 300, the held position to 0, the
//   output empties. Registers sit at byte addresses 0, 4, 8 and are to be
//   written only while the core is idle; the core does not enforce this.
module proximity_array_centroid_core
    import pac_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [SAMPLE_BITS-1:0]  right_side,
    input  logic [SAMPLE_BITS-1:0]  right_diag,
    input  logic [SAMPLE_BITS-1:0]  right_front,
    input  logic [SAMPLE_BITS-1:0]  left_front,
    input  logic [SAMPLE_BITS-1:0]  left_diag,
    input  logic [SAMPLE_BITS-1:0]  left_side,
    input  logic [SAMPLE_BITS-1:0]  floor_right,
    input  logic [SAMPLE_BITS-1:0]  floor_left,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [LEVEL_W-1:0]      level_0,
    output logic [LEVEL_W-1:0]      level_1,
    output logic [LEVEL_W-1:0]      level_2,
    output logic [LEVEL_W-1:0]      level_3,
    output logic [LEVEL_W-1:0]      level_4,
    output logic [LEVEL_W-1:0]      level_5,
    output logic                    line_right,
    output logic                    line_left,
    output logic signed [POS_W-1:0] position,
    output logic                    any_seen,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    logic [SAMPLE_BITS-1:0] detect_low_reg;
    logic [SAMPLE_BITS-1:0] detect_high_reg;
    logic [SAMPLE_BITS-1:0] line_level_reg;
    logic                   wr_en;
    pac_cmd_t               cmd;
    pac_status_t            status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // register writes; out-of-range indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detect_low_reg  <= DETECT_LOW_RST;
            detect_high_reg <= DETECT_HIGH_RST;
            line_level_reg  <= LINE_LEVEL_RST;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_DETECT_LOW:  detect_low_reg  <= pwdata[SAMPLE_BITS-1:0];
                REG_DETECT_HIGH: detect_high_reg <= pwdata[SAMPLE_BITS-1:0];
                REG_LINE_LEVEL:  line_level_reg  <= pwdata[SAMPLE_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_DETECT_LOW:  prdata = DATA_W'(detect_low_reg);
            REG_DETECT_HIGH: prdata = DATA_W'(detect_high_reg);
            REG_LINE_LEVEL:  prdata = DATA_W'(line_level_reg);
            default:         prdata = '0;
        endcase
    end

    pac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    pac_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .right_side  (right_side),
        .right_diag  (right_diag),
        .right_front (right_front),
        .left_front  (left_front),
        .left_diag   (left_diag),
        .left_side   (left_side),
        .floor_right (floor_right),
        .floor_left  (floor_left),
        .detect_low  (detect_low_reg),
        .detect_high (detect_high_reg),
        .line_level  (line_level_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .level_0     (level_0),
        .level_1     (level_1),
        .level_2     (level_2),
        .level_3     (level_3),
        .level_4     (level_4),
        .level_5     (level_5),
        .line_right  (line_right),
        .line_left   (line_left),
        .position    (position),
        .any_seen    (any_seen)
    );

endmodule

// ===== src/pac_div.sv =====
// Restoring divider, one quotient bit per cycle, with overflow flag.
// Depends on pac_pkg.
module pac_div
    import pac_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [DIVIDEND_W-1:0]  dividend,
    input  logic [SAMPLE_BITS-1:0] divisor,
    output logic                   done,
    output logic [QUOT_W-1:0]      quotient,
    output logic                   ovf
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [DIVIDEND_W-1:0] rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] dsh_reg, dsh_next;
    logic [QUOT_W-1:0]     quot_reg, quot_next;
    logic                  ovf_reg, ovf_next;
    logic [DIVIDEND_W:0]   div_top;
    logic                  fits;

    assign div_top = {divisor, {QUOT_W{1'b0}}};
    assign fits    = rem_reg >= dsh_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quot_next = quot_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = dividend;
            dsh_next  = {divisor, {(QUOT_W-1){1'b0}}};
            quot_next = '0;
            ovf_next  = {1'b0, dividend} >= div_top;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? rem_reg - dsh_reg : rem_reg;
            quot_next = {quot_reg[QUOT_W-2:0], fits};
            dsh_next  = dsh_reg >> 1;
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(QUOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        quot_reg <= quot_next;
        ovf_reg  <= ovf_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;
    assign ovf      = ovf_reg;

endmodule

// ===== src/pac_ctrl.sv =====
// Sequencer: walks the six sensors through the shared divider, then the centroid when a sensor sees.
// Depends on pac_pkg.
module pac_ctrl
    import pac_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  pac_status_t status,
    output pac_cmd_t    cmd
);

    pac_state_t       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.idx    = idx_reg;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    idx_next    = '0;
                    state_next  = ST_START;
                end
            end
            ST_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.level_store = 1'b1;
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_PSTART;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_START;
                    end
                end
            end
            ST_PSTART:
            begin
                // hold the old position when nothing was seen
                if (status.any_seen)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_pos   = 1'b1;
                    state_next    = ST_PWAIT;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_PWAIT:
            begin
                cmd.div_pos = 1'b1;
                if (status.div_done)
                begin
                    cmd.pos_store = 1'b1;
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/pac_dp.sv =====
// Datapath: scan capture, level scaling, centroid accumulation, output register.
// Depends on pac_pkg and pac_div.
module pac_dp
    import pac_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  pac_cmd_t               cmd,
    output pac_status_t            status,
    input  logic [SAMPLE_BITS-1:0] right_side,
    input  logic [SAMPLE_BITS-1:0] right_diag,
    input  logic [SAMPLE_BITS-1:0] right_front,
    input  logic [SAMPLE_BITS-1:0] left_front,
    input  logic [SAMPLE_BITS-1:0] left_diag,
    input  logic [SAMPLE_BITS-1:0] left_side,
    input  logic [SAMPLE_BITS-1:0] floor_right,
    input  logic [SAMPLE_BITS-1:0] floor_left,
    input  logic [SAMPLE_BITS-1:0] detect_low,
    input  logic [SAMPLE_BITS-1:0] detect_high,
    input  logic [SAMPLE_BITS-1:0] line_level,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [LEVEL_W-1:0]     level_0,
    output logic [LEVEL_W-1:0]     level_1,
    output logic [LEVEL_W-1:0]     level_2,
    output logic [LEVEL_W-1:0]     level_3,
    output logic [LEVEL_W-1:0]     level_4,
    output logic [LEVEL_W-1:0]     level_5,
    output logic                   line_right,
    output logic                   line_left,
    output logic signed [POS_W-1:0] position,
    output logic                   any_seen
);

    logic [SAMPLE_BITS-1:0] raw_reg [N_PROX];
    logic [LEVEL_W-1:0]     lvl_reg [N_PROX];
    logic                   line_r_reg, line_l_reg;
    logic [ACC_W-1:0]       acc_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [POS_W-1:0]       held_pos_reg;

    logic [LEVEL_W-1:0]     out_lvl_reg [N_PROX];
    logic                   out_line_r_reg, out_line_l_reg;
    logic [POS_W-1:0]       out_pos_reg;
    logic                   out_seen_reg;
    logic                   out_valid_reg;

    logic [SAMPLE_BITS-1:0] raw_sel, diff, span;
    logic                   below, degen;
    logic [DIVIDEND_W-1:0]  lvl_dividend, pos_dividend, div_dividend;
    logic [POS_DIV_W-1:0]   pos_div_raw;
    logic [SAMPLE_BITS-1:0] pos_divisor, div_divisor;
    logic                   div_done, div_ovf;
    logic [QUOT_W-1:0]      quot;
    logic [LEVEL_W-1:0]     level_calc;
    logic [ACC_W-1:0]       step_weight;

    assign raw_sel      = raw_reg[cmd.idx];
    assign below        = raw_sel < detect_low;
    assign degen        = detect_high <= detect_low;
    assign diff         = raw_sel - detect_low;
    assign span         = detect_high - detect_low;
    assign lvl_dividend = DIVIDEND_W'(diff) * DIVIDEND_W'(FULL_SCALE);
    assign pos_dividend = DIVIDEND_W'(acc_reg);
    assign pos_div_raw  = POS_DIV_W'(cnt_reg) * POS_DIV_W'(POS_STEP);
    assign pos_divisor  = SAMPLE_BITS'(pos_div_raw);
    assign div_dividend = cmd.div_pos ? pos_dividend : lvl_dividend;
    assign div_divisor  = cmd.div_pos ? pos_divisor : span;
    assign step_weight  = (ACC_W'(cmd.idx) + ACC_W'(1)) * ACC_W'(IDX_STEP);

    pac_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quot),
        .ovf      (div_ovf)
    );

    always_comb
    begin
        if (below)
            level_calc = '0;
        else if (degen || div_ovf || (quot > QUOT_W'(FULL_SCALE)))
            level_calc = LEVEL_W'(FULL_SCALE);
        else
            level_calc = quot[LEVEL_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            raw_reg[0] <= right_side;
            raw_reg[1] <= right_diag;
            raw_reg[2] <= right_front;
            raw_reg[3] <= left_front;
            raw_reg[4] <= left_diag;
            raw_reg[5] <= left_side;
            line_r_reg <= floor_right <= line_level;
            line_l_reg <= floor_left <= line_level;
            acc_reg    <= '0;
            cnt_reg    <= '0;
        end
        if (cmd.level_store)
        begin
            lvl_reg[cmd.idx] <= level_calc;
            if (level_calc != '0)
            begin
                acc_reg <= acc_reg + step_weight;
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
        if (cmd.publish)
        begin
            out_lvl_reg    <= lvl_reg;
            out_line_r_reg <= line_r_reg;
            out_line_l_reg <= line_l_reg;
            out_pos_reg    <= held_pos_reg;
            out_seen_reg   <= cnt_reg != '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_pos_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.pos_store)
                held_pos_reg <= POS_W'(quot) - POS_W'(POS_OFFSET);
            if (cmd.publish)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.div_done = div_done;
    assign status.any_seen = cnt_reg != '0;
    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign level_0    = out_lvl_reg[0];
    assign level_1    = out_lvl_reg[1];
    assign level_2    = out_lvl_reg[2];
    assign level_3    = out_lvl_reg[3];
    assign level_4    = out_lvl_reg[4];
    assign level_5    = out_lvl_reg[5];
    assign line_right = out_line_r_reg;
    assign line_left  = out_line_l_reg;
    assign position   = out_pos_reg;
    assign any_seen   = out_seen_reg;

endmodule

// ===== src/pac_checker.sv =====
// Port-level checks of the proximity array centroid core, bound to the top level.
// Depends on pac_pkg and proximity_array_centroid_core.
module pac_checker
    import pac_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic [LEVEL_W-1:0]      level_0,
    input logic [LEVEL_W-1:0]      level_1,
    input logic [LEVEL_W-1:0]      level_2,
    input logic [LEVEL_W-1:0]      level_3,
    input logic [LEVEL_W-1:0]      level_4,
    input logic [LEVEL_W-1:0]      level_5,
    input logic signed [POS_W-1:0] position,
    input logic                    any_seen
);

    logic [POS_W-1:0] last_pos_reg;
    logic             lvl_nonzero;

    assign lvl_nonzero = (level_0 != '0) || (level_1 != '0) || (level_2 != '0)
                      || (level_3 != '0) || (level_4 != '0) || (level_5 != '0);

    // track the position of the last delivered word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_pos_reg <= '0;
        else if (out_valid && !out_stall)
            last_pos_reg <= position;
    end

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(position) && $stable(level_0))
        else $error("stalled output word changed");

    a_seen_matches_levels: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (any_seen == lvl_nonzero))
        else $error("any_seen disagrees with levels");

    a_position_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !any_seen |-> position == last_pos_reg)
        else $error("position not held when nothing seen");

    a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (position >= -8'sd72) && (position <= 8'sd71))
        else $error("position out of range");

endmodule

bind proximity_array_centroid_core pac_checker u_checker (.*);

// ===== bench/proximity_array_centroid_core_test.sv =====
// Self-checking bench for proximity_array_centroid_core: scans in, levels and centroid out.
// Depends on pac_pkg and the core RTL; thresholds are programmed through the APB port.
module proximity_array_centroid_core_test
    import pac_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 600_000;
    localparam int CENTRE_MILLI = 3500;
    localparam int REPORT_CAP   = 100;
    localparam int SETTLE_CYCLES = 100;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef logic [SAMPLE_BITS-1:0] sample_t;

    // One scan as it enters the core.
    typedef struct packed {
        logic [N_PROX-1:0][SAMPLE_BITS-1:0] prox;
        sample_t                            floor_r;
        sample_t                            floor_l;
    } scan_t;

    // One result word as it leaves the core.
    typedef struct packed {
        logic [N_PROX-1:0][LEVEL_W-1:0] level;
        logic                           line_r;
        logic                           line_l;
        logic signed [POS_W-1:0]        pos;
        logic                           seen;
    } centroid_word_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic out_valid;
    logic out_stall;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    scan_t drive_scan;

    logic [LEVEL_W-1:0] level_0, level_1, level_2, level_3, level_4, level_5;
    logic line_right, line_left, any_seen;
    logic signed [POS_W-1:0] position;

    // Shadow of the programmed thresholds and of the position the core holds.
    sample_t thr_low;
    sample_t thr_high;
    sample_t thr_line;
    logic signed [POS_W-1:0] held_pos;

    centroid_word_t pending_words[$];

    int idle_pct;
    int stall_pct;
    int mismatch_count;
    int scans_sent;
    int words_seen;
    int settings_used;
    int cycle_count;

    proximity_array_centroid_core uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .right_side  (drive_scan.prox[0]),
        .right_diag  (drive_scan.prox[1]),
        .right_front (drive_scan.prox[2]),
        .left_front  (drive_scan.prox[3]),
        .left_diag   (drive_scan.prox[4]),
        .left_side   (drive_scan.prox[5]),
        .floor_right (drive_scan.floor_r),
        .floor_left  (drive_scan.floor_l),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .level_0     (level_0),
        .level_1     (level_1),
        .level_2     (level_2),
        .level_3     (level_3),
        .level_4     (level_4),
        .level_5     (level_5),
        .line_right  (line_right),
        .line_left   (line_left),
        .position    (position),
        .any_seen    (any_seen),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // 12 ns clock.
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Guard against a hung core: end the run as a failure past the limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Receiver back-pressure: redraw the stall at each falling edge.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Predict one result word from a scan, using the shadow thresholds and
    // the held position. Levels below one do not count as a detection.
    function automatic centroid_word_t predict_scan(scan_t s);
        centroid_word_t w;
        int acc;
        int cnt;
        int lvl;
        int avg;
        acc = 0;
        cnt = 0;
        for (int i = 0; i < N_PROX; i++)
        begin
            if (s.prox[i] < thr_low)
                lvl = 0;
            else if (thr_high <= thr_low)
                lvl = FULL_SCALE;
            else
            begin
                lvl = (int'(s.prox[i]) - int'(thr_low)) * FULL_SCALE
                      / (int'(thr_high) - int'(thr_low));
                if (lvl > FULL_SCALE)
                    lvl = FULL_SCALE;
            end
            w.level[i] = LEVEL_W'(lvl);
            if (lvl >= 1)
            begin
                acc += (i + 1) * IDX_STEP;
                cnt++;
            end
        end
        w.line_r = (s.floor_r <= thr_line);
        w.line_l = (s.floor_l <= thr_line);
        if (cnt > 0)
        begin
            avg = acc / cnt;
            w.pos = POS_W'(((avg - CENTRE_MILLI) - SPAN_LOW) * (POS_HIGH - POS_LOW)
                           / (SPAN_HIGH - SPAN_LOW) + POS_LOW);
        end
        else
            w.pos = held_pos;
        w.seen = (cnt > 0);
        return w;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Compare each accepted word with the oldest prediction.
    always @(posedge clk)
    begin
        centroid_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            words_seen++;
            if (pending_words.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected word, expected none, actual position %0d",
                         $time, position);
            end
            else
            begin
                want = pending_words.pop_front();
                check_field("level_0", want.level[0], level_0);
                check_field("level_1", want.level[1], level_1);
                check_field("level_2", want.level[2], level_2);
                check_field("level_3", want.level[3], level_3);
                check_field("level_4", want.level[4], level_4);
                check_field("level_5", want.level[5], level_5);
                check_field("line_right", want.line_r, line_right);
                check_field("line_left", want.line_l, line_left);
                check_field("position", int'(want.pos), int'(position));
                check_field("any_seen", want.seen, any_seen);
            end
        end
    end

    // Present one scan after a random gap, hold it through stalls, and
    // record the prediction at the edge that takes it.
    task automatic send_scan(input scan_t s);
        centroid_word_t w;
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        drive_scan = s;
        in_valid   = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        w = predict_scan(s);
        held_pos = w.pos;
        pending_words.push_back(w);
        scans_sent++;
    endtask

    // Drop valid and wait until every predicted word has come out.
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_words.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Two-phase APB write; junk in the upper data bits must be ignored.
    task automatic apb_write(input logic [1:0] idx, input sample_t value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = ($urandom() & ~DATA_W'(32'h3FF)) | DATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_DETECT_LOW:  thr_low  = value;
            REG_DETECT_HIGH: thr_high = value;
            REG_LINE_LEVEL:  thr_line = value;
            default: ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_thresholds(input int lo, input int hi, input int line);
        wait_drained();
        apb_write(REG_DETECT_LOW, sample_t'(lo));
        apb_write(REG_DETECT_HIGH, sample_t'(hi));
        apb_write(REG_LINE_LEVEL, sample_t'(line));
        settings_used++;
    endtask

    function automatic scan_t make_scan(input int a, input int b, input int c, input int d,
                                        input int e, input int f, input int fr, input int fl);
        scan_t s;
        s.prox[0] = sample_t'(a);
        s.prox[1] = sample_t'(b);
        s.prox[2] = sample_t'(c);
        s.prox[3] = sample_t'(d);
        s.prox[4] = sample_t'(e);
        s.prox[5] = sample_t'(f);
        s.floor_r = sample_t'(fr);
        s.floor_l = sample_t'(fl);
        return s;
    endfunction

    // Aim proximity samples at the threshold boundaries most of the time.
    function automatic sample_t pick_prox_sample();
        case ($urandom_range(7))
            0: return (thr_low == 0) ? sample_t'(0)
                                     : sample_t'($urandom_range(int'(thr_low) - 1, 0));
            1: return thr_low;
            2: return sample_t'($urandom_range(int'(thr_high), int'(thr_low)));
            3: return thr_high;
            4: return sample_t'($urandom_range(1023, int'(thr_high)));
            5: return sample_t'(0);
            6: return sample_t'(1023);
            default: return sample_t'($urandom());
        endcase
    endfunction

    function automatic sample_t pick_floor_sample();
        case ($urandom_range(3))
            0: return thr_line;
            1: return thr_line + sample_t'(1);
            2: return thr_line - sample_t'(1);
            default: return sample_t'($urandom());
        endcase
    endfunction

    // Mostly mixed scans; one in six is a quiet scan that should repeat the
    // held position.
    function automatic scan_t random_scan();
        scan_t s;
        logic quiet;
        quiet = ($urandom_range(5) == 0);
        for (int i = 0; i < N_PROX; i++)
        begin
            if (quiet)
                s.prox[i] = (thr_low == 0) ? sample_t'(0)
                                           : sample_t'($urandom_range(int'(thr_low) - 1, 0));
            else
                s.prox[i] = pick_prox_sample();
        end
        s.floor_r = pick_floor_sample();
        s.floor_l = pick_floor_sample();
        return s;
    endfunction

    task automatic random_thresholds();
        int lo;
        int hi;
        int line;
        case ($urandom_range(9))
            0:
            begin
                lo = $urandom_range(1023);
                hi = lo;
            end
            1:
            begin
                lo = $urandom_range(1023, 1);
                hi = $urandom_range(lo - 1, 0);
            end
            2:
            begin
                lo = 0;
                hi = 1023;
            end
            3:
            begin
                lo = $urandom_range(1022);
                hi = lo + 1;
            end
            default:
            begin
                lo = $urandom_range(700);
                hi = $urandom_range(1023, lo + 1);
            end
        endcase
        case ($urandom_range(4))
            0: line = 0;
            1: line = 1023;
            default: line = $urandom_range(1023);
        endcase
        set_thresholds(lo, hi, line);
        // now and then poke the unused slot, which must change nothing
        if ($urandom_range(3) == 0)
            apb_write(REG_UNUSED, sample_t'($urandom()));
    endtask

    // Reset thresholds: empty scan, full scan, each sensor alone, and the
    // edges of the scaling range and the line threshold.
    task automatic test_reset_thresholds();
        send_scan(make_scan(0, 0, 0, 0, 0, 0, 0, 0));
        send_scan(make_scan(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023));
        for (int i = 0; i < N_PROX; i++)
        begin
            scan_t s;
            s = make_scan(0, 0, 0, 0, 0, 0, 300, 301);
            s.prox[i] = sample_t'(350);
            send_scan(s);
        end
        // at detect_low the level is still zero: hold the last position
        send_scan(make_scan(100, 100, 100, 100, 100, 100, 300, 301));
        send_scan(make_scan(99, 600, 601, 101, 1023, 0, 299, 0));
        // smallest sample that truncates to level one
        send_scan(make_scan(0, 0, 0, 104, 105, 0, 1023, 300));
    endtask

    // High threshold at or below the low one: saturate at and above low.
    task automatic test_degenerate_thresholds();
        set_thresholds(500, 500, 300);
        send_scan(make_scan(499, 500, 1023, 0, 0, 0, 0, 1023));
        set_thresholds(800, 200, 300);
        send_scan(make_scan(799, 800, 900, 0, 199, 1023, 1023, 0));
    endtask

    task automatic test_extreme_thresholds();
        set_thresholds(0, 0, 0);
        send_scan(make_scan(0, 0, 0, 0, 0, 0, 0, 1));
        set_thresholds(1023, 1023, 1023);
        send_scan(make_scan(1022, 1023, 1022, 1022, 1023, 1022, 1023, 1022));
        set_thresholds(0, 1023, 512);
        send_scan(make_scan(1, 1023, 512, 10, 11, 0, 512, 513));
        send_scan(make_scan(0, 0, 0, 0, 0, 0, 0, 0));
    endtask

    // The unused register slot and upper data bits must have no effect.
    task automatic test_ignored_writes();
        set_thresholds(100, 600, 300);
        apb_write(REG_UNUSED, sample_t'(5));
        send_scan(make_scan(350, 0, 0, 0, 0, 700, 300, 301));
    endtask

    task automatic test_random_scans();
        int phase_idle[4]  = '{0, 70, 0, 38};
        int phase_stall[4] = '{0, 0, 70, 38};
        for (int p = 0; p < 4; p++)
        begin
            wait_drained();
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            for (int n = 0; n < 212; n++)
            begin
                if (n % 70 == 0)
                    random_thresholds();
                // occasionally let the core empty out before the next scan
                if ($urandom_range(49) == 0)
                    wait_drained();
                send_scan(random_scan());
            end
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        out_stall      = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        drive_scan     = '0;
        thr_low        = DETECT_LOW_RST;
        thr_high       = DETECT_HIGH_RST;
        thr_line       = LINE_LEVEL_RST;
        held_pos       = '0;
        idle_pct       = 0;
        stall_pct      = 0;
        mismatch_count = 0;
        scans_sent     = 0;
        words_seen     = 0;
        settings_used  = 1;
        cycle_count    = 0;

        // hold reset, then release it on a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_thresholds();
        test_degenerate_thresholds();
        test_extreme_thresholds();
        test_ignored_writes();
        test_random_scans();

        // drain, then watch for stray words a while longer
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Sent %0d scans, checked %0d words across %0d threshold settings,",
                 scans_sent, words_seen, settings_used);
        $display("with free-running, idle, stall and mixed handshake phases.");
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
